@@ src/occupancy_grid_nearest_free_search_core_assert.svh @@
// Assertion helpers for the nearest-free search core.
`ifndef OCCUPANCY_GRID_NEAREST_FREE_SEARCH_CORE_ASSERT_SVH
`define OCCUPANCY_GRID_NEAREST_FREE_SEARCH_CORE_ASSERT_SVH

// Condition must hold whenever the antecedent holds (same edge).
`define OGNS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must hold on the edge after the antecedent.
`define OGNS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ogns_pkg.sv @@
package ogns_pkg;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int MAX_FOUND_DEF  = 16;
    localparam int OWNER_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [CFG_DATA_W-1:0] MAP_SIZE_RESET = 7'd64;

    typedef enum logic [2:0] {
        MODE_QUERY_VALID = 3'd0,
        MODE_QUERY_OCC   = 3'd1,
        MODE_TRY_OCCUPY  = 3'd2,
        MODE_OCCUPY      = 3'd3,
        MODE_LEAVE       = 3'd4,
        MODE_BLOCK       = 3'd5,
        MODE_FREE        = 3'd6,
        MODE_FIND_NEAR   = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_OUTSIDE  = 2'd1,
        STAT_MISMATCH = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL,
        ST_SEARCH,
        ST_DRAIN,
        ST_NONE,
        ST_OUT_RD,
        ST_OUT_WR
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } ring_ctl_t;

    // Diamond walk directions, one per ring side.
    function automatic logic signed [1:0] ring_dx(input logic [1:0] d);
        case (d)
            2'd0:    ring_dx = 2'sd1;
            2'd1:    ring_dx = 2'sd1;
            default: ring_dx = -2'sd1;
        endcase
    endfunction

    function automatic logic signed [1:0] ring_dy(input logic [1:0] d);
        case (d)
            2'd0:    ring_dy = 2'sd1;
            2'd3:    ring_dy = 2'sd1;
            default: ring_dy = -2'sd1;
        endcase
    endfunction

endpackage

@@ src/ogns_ram.sv @@
module ogns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/ogns_ring_gen.sv @@
module ogns_ring_gen #(
    parameter int CW = 16,
    parameter int RW = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ogns_pkg::ring_ctl_t   ctl,
    input  logic signed [CW-1:0]  start_x,
    input  logic signed [CW-1:0]  start_y,
    input  logic [RW-1:0]         rings,
    output logic signed [CW-1:0]  cand_x,
    output logic signed [CW-1:0]  cand_y,
    output logic                  cand_last
);

    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic [RW-1:0]        r_reg, r_next, j_reg, j_next, rings_reg, rings_next;
    logic [1:0]           d_reg, d_next;
    logic                 first_reg, first_next;
    logic [RW:0]          j_inc, r_inc;
    logic [1:0]           d_inc;

    assign j_inc = {1'b0, j_reg} + {{RW{1'b0}}, 1'b1};
    assign r_inc = {1'b0, r_reg} + {{RW{1'b0}}, 1'b1};
    assign d_inc = d_reg + 2'd1;

    assign cand_x = x_reg;
    assign cand_y = y_reg;
    // final candidate: start cell with no rings, or end of the outermost ring
    assign cand_last = first_reg ? (rings_reg <= {{(RW-1){1'b0}}, 1'b1})
                                 : (d_reg == 2'd3 && j_inc == {1'b0, r_reg}
                                    && r_inc >= {1'b0, rings_reg});

    always_comb
    begin
        x_next     = x_reg;
        y_next     = y_reg;
        r_next     = r_reg;
        j_next     = j_reg;
        d_next     = d_reg;
        first_next = first_reg;
        rings_next = rings_reg;
        if (ctl.load)
        begin
            x_next     = start_x;
            y_next     = start_y;
            r_next     = '0;
            j_next     = '0;
            d_next     = '0;
            first_next = 1'b1;
            rings_next = rings;
        end
        else if (ctl.step)
        begin
            if (first_reg || (d_reg == 2'd3 && j_inc >= {1'b0, r_reg}))
            begin
                // next ring starts one row above the previous end point
                first_next = 1'b0;
                r_next     = RW'(r_inc);
                j_next     = '0;
                d_next     = '0;
                y_next     = y_reg + CW'(1);
            end
            else if (j_inc < {1'b0, r_reg})
            begin
                j_next = RW'(j_inc);
                x_next = x_reg + CW'(ogns_pkg::ring_dx(d_reg));
                y_next = y_reg + CW'(ogns_pkg::ring_dy(d_reg));
            end
            else
            begin
                d_next = d_inc;
                j_next = '0;
                x_next = x_reg + CW'(ogns_pkg::ring_dx(d_inc));
                y_next = y_reg + CW'(ogns_pkg::ring_dy(d_inc));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg     <= '0;
            j_reg     <= '0;
            d_reg     <= '0;
            first_reg <= 1'b0;
            rings_reg <= '0;
        end
        else
        begin
            r_reg     <= r_next;
            j_reg     <= j_next;
            d_reg     <= d_next;
            first_reg <= first_next;
            rings_reg <= rings_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

endmodule

@@ src/occupancy_grid_nearest_free_search_core.sv @@
// Sequence: cell modes read the grid entry on accept, then modify it, write it back and
//   load the result; find-near walks ring cells, then per returned cell reads the found list
//   and loads the output. Throughput: one request at a time; a cell request is held off
//   by the grid memory read-modify-write; find-near is bounded by its one-read-per-cycle walk.
// Reset: async active low; a clearing pass then writes every grid entry while in_stall is
//   high; config writes are taken throughout.
module occupancy_grid_nearest_free_search_core #(
    parameter int MAX_WIDTH  = ogns_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ogns_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_FOUND  = ogns_pkg::MAX_FOUND_DEF,
    parameter int OWNER_BITS = ogns_pkg::OWNER_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     mode,
    input  logic signed [7:0]              query_x,
    input  logic signed [7:0]              query_y,
    input  logic [15:0]                    owner_id,
    input  logic [4:0]                     wanted_count,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [6:0]              cell_x,
    output logic signed [6:0]              cell_y,
    output logic                           answer,
    output logic [1:0]                     status,
    output logic [15:0]                    cell_owner,
    output logic                           last,
    // configuration channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ogns_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ogns_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int XB    = $clog2(MAX_WIDTH);
    localparam int YB    = $clog2(MAX_HEIGHT);
    localparam int RW    = $clog2(MAX_WIDTH + MAX_HEIGHT + 1);
    // ring coordinates reach start +/- (width + height)
    localparam int CW    = RW + 10;
    localparam int FAW   = (MAX_FOUND > 1) ? $clog2(MAX_FOUND) : 1;
    localparam int FCW   = $clog2(MAX_FOUND + 1);
    localparam int GW    = OWNER_BITS + 1;
    localparam int FW    = XB + YB + OWNER_BITS;

    // ---------------- configuration ----------------
    logic [ogns_pkg::CFG_DATA_W-1:0] width_reg, height_reg;
    logic [RW-1:0] eff_w, eff_h, rings;
    logic signed [CW-1:0] eff_w_s, eff_h_s;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ogns_pkg::MAP_SIZE_RESET;
            height_reg <= ogns_pkg::MAP_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == ogns_pkg::REG_MAP_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else if (cfg_index == ogns_pkg::REG_MAP_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
        end
    end

    // sizes above the array bounds saturate
    assign eff_w   = (int'(width_reg) > MAX_WIDTH) ? RW'(MAX_WIDTH) : RW'(width_reg);
    assign eff_h   = (int'(height_reg) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(height_reg);
    assign rings   = eff_w + eff_h;
    assign eff_w_s = $signed(CW'(eff_w));
    assign eff_h_s = $signed(CW'(eff_h));

    function automatic logic in_map(input logic signed [CW-1:0] x,
                                    input logic signed [CW-1:0] y,
                                    input logic signed [CW-1:0] w,
                                    input logic signed [CW-1:0] h);
        in_map = !x[CW-1] && !y[CW-1] && (x < w) && (y < h);
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [XB-1:0] x,
                                              input logic [YB-1:0] y);
        addr_of = AW'(int'(y) * MAX_WIDTH + int'(x));
    endfunction

    // ---------------- state ----------------
    ogns_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   clr_cnt_reg;
    ogns_pkg::mode_t mode_reg;
    logic            inmap_reg;
    logic [XB-1:0]   qx_reg;
    logic [YB-1:0]   qy_reg;
    logic [OWNER_BITS-1:0] id_reg;
    logic [FCW-1:0]  want_reg, found_cnt_reg, k_reg;
    logic            s2_valid_reg, s2_inmap_reg;
    logic [XB-1:0]   s2_x_reg;
    logic [YB-1:0]   s2_y_reg;

    logic in_accept;
    logic out_free;
    logic signed [CW-1:0] qx_ext, qy_ext;
    logic q_inmap;

    assign in_stall  = (state_reg != ogns_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid || !out_stall;
    assign qx_ext    = CW'(query_x);
    assign qy_ext    = CW'(query_y);
    assign q_inmap   = in_map(qx_ext, qy_ext, eff_w_s, eff_h_s);

    // ---------------- ring walker ----------------
    ogns_pkg::ring_ctl_t ring_ctl;
    logic signed [CW-1:0] cand_x, cand_y;
    logic cand_last, cand_inmap;

    ogns_ring_gen #(
        .CW (CW),
        .RW (RW)
    ) u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ring_ctl),
        .start_x   (qx_ext),
        .start_y   (qy_ext),
        .rings     (rings),
        .cand_x    (cand_x),
        .cand_y    (cand_y),
        .cand_last (cand_last)
    );

    assign cand_inmap = in_map(cand_x, cand_y, eff_w_s, eff_h_s);

    // ---------------- grid memory: {occupied, owner} ----------------
    logic          grid_we, grid_re;
    logic [AW-1:0] grid_waddr, grid_raddr;
    logic [GW-1:0] grid_wdata, grid_rdata;

    ogns_ram #(
        .WIDTH (GW),
        .DEPTH (CELLS)
    ) u_grid (
        .clk   (clk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_wdata),
        .re    (grid_re),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    // ---------------- found list: {x, y, owner} ----------------
    logic          found_we, found_re;
    logic [FAW-1:0] found_waddr, found_raddr;
    logic [FW-1:0] found_wdata, found_rdata;

    ogns_ram #(
        .WIDTH (FW),
        .DEPTH (MAX_FOUND)
    ) u_found (
        .clk   (clk),
        .we    (found_we),
        .waddr (found_waddr),
        .wdata (found_wdata),
        .re    (found_re),
        .raddr (found_raddr),
        .rdata (found_rdata)
    );

    // ---------------- search stage 2: grid data back, check free ----------------
    logic grid_occ;
    logic [OWNER_BITS-1:0] grid_owner;
    logic s2_hit, s2_done;

    assign grid_occ   = grid_rdata[GW-1];
    assign grid_owner = grid_rdata[OWNER_BITS-1:0];
    assign s2_hit     = s2_valid_reg && s2_inmap_reg && !grid_occ
                        && (found_cnt_reg < want_reg);
    assign s2_done    = s2_hit
                        && (({1'b0, found_cnt_reg} + {{FCW{1'b0}}, 1'b1}) == {1'b0, want_reg});

    assign found_we    = s2_hit;
    assign found_waddr = found_cnt_reg[FAW-1:0];
    assign found_wdata = {s2_x_reg, s2_y_reg, grid_owner};

    // ---------------- cell modes: modify ----------------
    logic cell_ans, cell_wr, cell_wocc;
    logic [OWNER_BITS-1:0] cell_wown;
    ogns_pkg::status_t cell_st;

    always_comb
    begin
        cell_ans  = 1'b1;
        cell_st   = ogns_pkg::STAT_OK;
        cell_wr   = 1'b0;
        cell_wocc = grid_occ;
        cell_wown = grid_owner;
        case (mode_reg)
            ogns_pkg::MODE_QUERY_VALID: cell_ans = !grid_occ;
            ogns_pkg::MODE_QUERY_OCC:   cell_ans = grid_occ;
            ogns_pkg::MODE_TRY_OCCUPY:
            begin
                if (grid_occ)
                begin
                    cell_ans = 1'b0;
                end
                else
                begin
                    cell_wr   = 1'b1;
                    cell_wocc = 1'b1;
                    cell_wown = id_reg;
                end
            end
            ogns_pkg::MODE_OCCUPY:
            begin
                cell_wr   = 1'b1;
                cell_wocc = 1'b1;
                cell_wown = id_reg;
            end
            ogns_pkg::MODE_LEAVE:
            begin
                if (grid_owner == id_reg)
                begin
                    cell_wr   = 1'b1;
                    cell_wocc = 1'b0;
                    cell_wown = '0;
                end
                else
                begin
                    cell_ans = 1'b0;
                    cell_st  = ogns_pkg::STAT_MISMATCH;
                end
            end
            ogns_pkg::MODE_BLOCK:
            begin
                cell_wr   = 1'b1;
                cell_wocc = 1'b1;
            end
            ogns_pkg::MODE_FREE:
            begin
                cell_wr   = 1'b1;
                cell_wocc = 1'b0;
            end
            default:
            begin
                cell_ans = 1'b1;
            end
        endcase
        if (!inmap_reg)
        begin
            cell_ans = 1'b0;
            cell_st  = ogns_pkg::STAT_OUTSIDE;
            cell_wr  = 1'b0;
        end
    end

    // ---------------- next state ----------------
    logic k_last;
    assign k_last = ({1'b0, k_reg} + {{FCW{1'b0}}, 1'b1}) == {1'b0, found_cnt_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ogns_pkg::ST_CLEAR:
                if (clr_cnt_reg == AW'(CELLS - 1)) state_next = ogns_pkg::ST_IDLE;
            ogns_pkg::ST_IDLE:
                if (in_accept)
                begin
                    state_next = (ogns_pkg::mode_t'(mode) == ogns_pkg::MODE_FIND_NEAR)
                                 ? ogns_pkg::ST_SEARCH : ogns_pkg::ST_CELL;
                end
            ogns_pkg::ST_CELL:
                if (out_free) state_next = ogns_pkg::ST_IDLE;
            ogns_pkg::ST_SEARCH:
                if (s2_done)        state_next = ogns_pkg::ST_OUT_RD;
                else if (cand_last) state_next = ogns_pkg::ST_DRAIN;
            ogns_pkg::ST_DRAIN:
                state_next = s2_done ? ogns_pkg::ST_OUT_RD : ogns_pkg::ST_NONE;
            ogns_pkg::ST_NONE:
                if (out_free) state_next = ogns_pkg::ST_IDLE;
            ogns_pkg::ST_OUT_RD:
                state_next = ogns_pkg::ST_OUT_WR;
            ogns_pkg::ST_OUT_WR:
                if (out_free) state_next = k_last ? ogns_pkg::ST_IDLE : ogns_pkg::ST_OUT_RD;
            default:
                state_next = ogns_pkg::ST_IDLE;
        endcase
    end

    // ---------------- datapath controls ----------------
    logic out_load;
    logic signed [6:0] out_x_next, out_y_next;
    logic out_ans_next, out_last_next;
    logic [1:0] out_st_next;
    logic [15:0] out_own_next;

    always_comb
    begin
        grid_we       = 1'b0;
        grid_waddr    = clr_cnt_reg;
        grid_wdata    = '0;
        grid_re       = 1'b0;
        grid_raddr    = addr_of(qx_ext[XB-1:0], qy_ext[YB-1:0]);
        found_re      = 1'b0;
        found_raddr   = k_reg[FAW-1:0];
        ring_ctl      = '0;
        out_load      = 1'b0;
        out_x_next    = 7'(qx_reg);
        out_y_next    = 7'(qy_reg);
        out_ans_next  = cell_ans;
        out_st_next   = cell_st;
        out_own_next  = 16'(grid_owner);
        out_last_next = 1'b1;
        case (state_reg)
            ogns_pkg::ST_CLEAR:
                grid_we = 1'b1;
            ogns_pkg::ST_IDLE:
            begin
                ring_ctl.load = in_accept;
                grid_re = in_accept && q_inmap
                          && (ogns_pkg::mode_t'(mode) != ogns_pkg::MODE_FIND_NEAR);
            end
            ogns_pkg::ST_CELL:
            begin
                out_load   = out_free;
                grid_we    = out_free && cell_wr;
                grid_waddr = addr_of(qx_reg, qy_reg);
                grid_wdata = {cell_wocc, cell_wown};
                if (!inmap_reg)
                begin
                    out_x_next   = -7'sd1;
                    out_y_next   = -7'sd1;
                    out_own_next = '0;
                end
            end
            ogns_pkg::ST_SEARCH:
            begin
                ring_ctl.step = !s2_done;
                grid_re       = cand_inmap && !s2_done;
                grid_raddr    = addr_of(cand_x[XB-1:0], cand_y[YB-1:0]);
            end
            ogns_pkg::ST_NONE:
            begin
                out_load     = out_free;
                out_x_next   = -7'sd1;
                out_y_next   = -7'sd1;
                out_ans_next = 1'b0;
                out_st_next  = ogns_pkg::STAT_NOT_FOUND;
                out_own_next = '0;
            end
            ogns_pkg::ST_OUT_RD:
                found_re = 1'b1;
            ogns_pkg::ST_OUT_WR:
            begin
                out_load      = out_free;
                out_x_next    = 7'(found_rdata[FW-1 -: XB]);
                out_y_next    = 7'(found_rdata[OWNER_BITS +: YB]);
                out_ans_next  = 1'b1;
                out_st_next   = ogns_pkg::STAT_OK;
                out_own_next  = 16'(found_rdata[OWNER_BITS-1:0]);
                out_last_next = k_last;
            end
            default:
                grid_we = 1'b0;
        endcase
    end

    // request capture; want is clamped to 1..MAX_FOUND
    logic [FCW-1:0] want_next;
    always_comb
    begin
        if (wanted_count == 5'd0)
            want_next = FCW'(1);
        else if (int'(wanted_count) > MAX_FOUND)
            want_next = FCW'(MAX_FOUND);
        else
            want_next = FCW'(wanted_count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ogns_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            found_cnt_reg <= '0;
            k_reg         <= '0;
            s2_valid_reg  <= 1'b0;
            out_valid     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s2_valid_reg <= (state_reg == ogns_pkg::ST_SEARCH) && !s2_done;
            if (state_reg == ogns_pkg::ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (in_accept)
            begin
                found_cnt_reg <= '0;
                k_reg         <= '0;
            end
            else
            begin
                if (s2_hit) found_cnt_reg <= found_cnt_reg + FCW'(1);
                if (state_reg == ogns_pkg::ST_OUT_WR && out_free) k_reg <= k_reg + FCW'(1);
            end
            if (out_load)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg  <= ogns_pkg::mode_t'(mode);
            inmap_reg <= q_inmap;
            qx_reg    <= qx_ext[XB-1:0];
            qy_reg    <= qy_ext[YB-1:0];
            id_reg    <= OWNER_BITS'(owner_id);
            want_reg  <= want_next;
        end
        s2_inmap_reg <= cand_inmap;
        s2_x_reg     <= cand_x[XB-1:0];
        s2_y_reg     <= cand_y[YB-1:0];
        if (out_load)
        begin
            cell_x     <= out_x_next;
            cell_y     <= out_y_next;
            answer     <= out_ans_next;
            status     <= out_st_next;
            cell_owner <= out_own_next;
            last       <= out_last_next;
        end
    end

    // ---------------- checks ----------------
`include "occupancy_grid_nearest_free_search_core_assert.svh"

    `OGNS_ASSERT_NOW(a_found_bound, (state_reg == ogns_pkg::ST_SEARCH || state_reg == ogns_pkg::ST_DRAIN), (found_cnt_reg < want_reg), "found count overran wanted count")
    `OGNS_ASSERT_NOW(a_grid_write_owner, grid_we, (state_reg == ogns_pkg::ST_CLEAR || state_reg == ogns_pkg::ST_CELL), "grid written outside clear or cell update")
    `OGNS_ASSERT_NOW(a_out_index, (state_reg == ogns_pkg::ST_OUT_RD), (k_reg < found_cnt_reg), "found list read past its fill")
    `OGNS_ASSERT_NEXT(a_search_exit, (state_reg == ogns_pkg::ST_DRAIN && !s2_done), (state_reg == ogns_pkg::ST_NONE), "short search did not report not-found")

endmodule
